// ----- rtl/vcpp_pkg.sv -----
// Shared types and constants for the Viterbi change-point pass.
// No dependencies.
`default_nettype none
package vcpp_pkg;

  localparam int COST_W = 48;
  localparam int NEXT_W = 50;
  localparam int DWELL_W = 10;

  localparam logic [45:0] HUBER_MAX = {46{1'b1}};
  localparam logic [DWELL_W-1:0] DWELL_MAX = {DWELL_W{1'b1}};
  localparam logic [7:0] COUNT_MAX = 8'hFF;
  localparam logic [31:0] SCALE_ONE = 32'h0001_0000;

  localparam logic [2:0] CFG_PENALTY = 3'd0;
  localparam logic [2:0] CFG_DWELL   = 3'd1;
  localparam logic [2:0] CFG_MERGE   = 3'd2;
  localparam logic [2:0] CFG_KNEE    = 3'd3;
  localparam logic [2:0] CFG_CONFIRM = 3'd4;

  typedef logic signed [COST_W-1:0] cost_t;

  typedef struct packed {
    logic signed [31:0] centre;
    logic [31:0]        scale;
    logic signed [31:0] offset;
  } regime_t;

  typedef struct packed {
    logic signed [NEXT_W-1:0] cost;
    logic [DWELL_W-1:0]       dwell;
  } path_entry_t;

endpackage
`default_nettype wire

// ----- rtl/viterbi_change_point_pass.sv -----
// Viterbi change-point pass: a sample item runs every regime through the shared cost
// pipeline, then the single compare-add step over every regime pair, then a sweep that
// normalises the path metrics, then the decision; a load item does not hold the input.
// One item at a time; the result register lets a new item in while a result waits,
// and a second change point holds the pass in DEC until the waiting beat is taken.
// Reset (synchronous, rst_n low) restores registers and table defaults; no clearing sweep.
`default_nettype none
module viterbi_change_point_pass #(
  parameter int REGIMES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic signed [31:0] in_sample_value,
  input  logic [3:0]         in_regime_slot,
  input  logic signed [31:0] in_regime_mean,
  input  logic [31:0]        in_regime_inv_std,
  input  logic signed [31:0] in_regime_log_cost,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_change_index,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);
  import vcpp_pkg::*;

  localparam int RW = (REGIMES > 1) ? $clog2(REGIMES) : 1;
  localparam int CW = $clog2(REGIMES + 1);
  localparam logic [CW-1:0] LAST = CW'(REGIMES - 1);

  typedef enum logic [3:0] {
    IDLE, C_RD, C_GO, C_WT, S_RD, S_LAT, P_RD, P_EV, N_RD, N_WR, DEC
  } state_t;

  // configuration
  logic [30:0] penalty_r, knee_r;
  logic [9:0]  min_dwell_r;
  logic [15:0] merge_r;
  logic [7:0]  confirm_r;

  // sequencer
  state_t      state_r;
  logic [CW-1:0] s_r, k_r;
  logic signed [31:0] sample_r;
  logic        bank_r;
  cost_t       cs_r;
  logic signed [50:0] best_r;
  logic [RW-1:0] from_r;
  logic [9:0]  dwell_s_r;
  logic signed [NEXT_W-1:0] lowest_r;
  logic [3:0]  best_reg_r;

  // decision state
  logic [31:0] count_r, last_r, cand_start_r;
  logic [3:0]  confirmed_r, cand_reg_r;
  logic        cand_valid_r;
  logic [7:0]  cand_cnt_r;

  logic        out_valid_r;
  logic [31:0] out_idx_r;

  // per-regime cost scratch
  cost_t       cost_mem [REGIMES];
  cost_t       cost_rd_r;
  logic [RW-1:0] cost_rd_idx;

  // submodule wiring
  logic        load_acc, samp_acc;
  regime_t     tbl_wr, tbl_rd;
  logic        tbl_we;
  logic        cu_done;
  cost_t       cu_cost;
  logic        pm_we, pm_wr_bank, pm_rd_bank;
  logic [RW-1:0] pm_wr_idx, pm_rd_idx;
  path_entry_t pm_wr, pm_rd;

  // pair evaluation
  logic        self_k, allowed;
  logic signed [50:0] cand_cost, best_n;
  logic [RW-1:0] from_n;
  logic [9:0]  dw_self, dw_new;
  logic signed [NEXT_W-1:0] next_cost;
  logic signed [50:0] norm;
  logic [NEXT_W-1:0] norm_sat;

  // decision
  logic        change, same_cand, confirm_hit, emit, blocked;
  logic [7:0]  cnt_n;
  logic [31:0] start_n;

  assign in_stall  = (state_r != IDLE);
  assign load_acc  = in_valid && !in_stall && in_kind;
  assign samp_acc  = in_valid && !in_stall && !in_kind;
  assign tbl_we    = load_acc && ({1'b0, in_regime_slot} < 5'(REGIMES));
  assign tbl_wr    = '{centre: in_regime_mean, scale: in_regime_inv_std,
                       offset: in_regime_log_cost};

  vcpp_regime_mem #(.REGIMES(REGIMES), .RW(RW)) u_tbl (
    .clk, .rst_n, .we(tbl_we), .wr_idx(in_regime_slot[RW-1:0]), .wr_data(tbl_wr),
    .rd_idx(s_r[RW-1:0]), .rd_data(tbl_rd)
  );

  vcpp_cost_unit u_cost (
    .clk, .rst_n, .start(state_r == C_GO), .sample(sample_r), .regime(tbl_rd),
    .knee(knee_r), .done(cu_done), .cost(cu_cost)
  );

  vcpp_path_mem #(.REGIMES(REGIMES), .RW(RW)) u_path (
    .clk, .rst_n, .clear(load_acc), .we(pm_we), .wr_bank(pm_wr_bank),
    .wr_idx(pm_wr_idx), .wr_data(pm_wr), .rd_bank(pm_rd_bank), .rd_idx(pm_rd_idx),
    .rd_data(pm_rd)
  );

  // cost scratch memory: one write, one registered read
  assign cost_rd_idx = (state_r == S_RD) ? s_r[RW-1:0] : k_r[RW-1:0];
  always_ff @(posedge clk) begin
    if (state_r == C_WT && cu_done) begin
      cost_mem[s_r[RW-1:0]] <= cu_cost;
    end
    cost_rd_r <= cost_mem[cost_rd_idx];
  end

  // compare-add step for predecessor k of regime s
  always_comb begin
    self_k    = (k_r == s_r);
    allowed   = self_k || ((pm_rd.dwell >= min_dwell_r) && (cost_rd_r > cs_r));
    cand_cost = 51'(pm_rd.cost) + (self_k ? 51'sd0 : $signed({20'b0, penalty_r}));
    best_n    = best_r;
    from_n    = from_r;
    if (allowed && cand_cost < best_r) begin
      best_n = cand_cost;
      from_n = k_r[RW-1:0];
    end
    dw_self   = self_k ? pm_rd.dwell : dwell_s_r;
    if (from_n == s_r[RW-1:0]) begin
      dw_new = (dw_self == DWELL_MAX) ? DWELL_MAX : dw_self + 10'd1;
    end else begin
      dw_new = 10'd1;
    end
    next_cost = NEXT_W'(best_n + 51'(cs_r));
    norm      = 51'(pm_rd.cost) - 51'(lowest_r);
    norm_sat  = (norm[50:48] != '0) ? NEXT_W'({48{1'b1}}) : NEXT_W'(norm);
  end

  // path memory port control
  always_comb begin
    pm_rd_bank = (state_r == N_RD) ? ~bank_r : bank_r;
    pm_rd_idx  = (state_r == N_RD) ? s_r[RW-1:0] : k_r[RW-1:0];
    pm_wr_bank = ~bank_r;
    pm_wr_idx  = s_r[RW-1:0];
    pm_we      = 1'b0;
    pm_wr      = '{cost: next_cost, dwell: dw_new};
    if (state_r == P_EV && k_r == LAST) begin
      pm_we = 1'b1;
    end else if (state_r == N_WR) begin
      pm_we = 1'b1;
      pm_wr = '{cost: $signed(norm_sat), dwell: pm_rd.dwell};
    end
  end

  // change-point confirmation
  always_comb begin
    change    = (best_reg_r != confirmed_r);
    same_cand = cand_valid_r && (cand_reg_r == best_reg_r);
    if (same_cand) begin
      cnt_n   = (cand_cnt_r == COUNT_MAX) ? COUNT_MAX : cand_cnt_r + 8'd1;
      start_n = cand_start_r;
    end else begin
      cnt_n   = 8'd1;
      start_n = count_r;
    end
    confirm_hit = (cnt_n >= confirm_r);
    emit    = change && confirm_hit && ((start_n - last_r) >= {16'b0, merge_r});
    blocked = emit && out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      penalty_r   <= 31'd65536;
      min_dwell_r <= 10'd1;
      merge_r     <= '0;
      knee_r      <= 31'd98304;
      confirm_r   <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PENALTY: penalty_r   <= cfg_data;
        CFG_DWELL:   min_dwell_r <= cfg_data[9:0];
        CFG_MERGE:   merge_r     <= cfg_data[15:0];
        CFG_KNEE:    knee_r      <= cfg_data;
        CFG_CONFIRM: confirm_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= IDLE;
      s_r          <= '0;
      k_r          <= '0;
      bank_r       <= 1'b0;
      count_r      <= '0;
      last_r       <= '0;
      confirmed_r  <= '0;
      cand_valid_r <= 1'b0;
      cand_reg_r   <= '0;
      cand_cnt_r   <= '0;
      cand_start_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // a new change point may replace a beat taken at this same edge
      if (state_r == DEC && emit && !blocked) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (load_acc) begin
            count_r      <= '0;
            last_r       <= '0;
            confirmed_r  <= '0;
            cand_valid_r <= 1'b0;
            cand_reg_r   <= '0;
            cand_cnt_r   <= '0;
            cand_start_r <= '0;
          end else if (samp_acc) begin
            sample_r <= in_sample_value;
            s_r      <= '0;
            state_r  <= C_RD;
          end
        end
        C_RD: state_r <= C_GO;
        C_GO: state_r <= C_WT;
        C_WT: begin
          if (cu_done) begin
            if (s_r == LAST) begin
              s_r     <= '0;
              state_r <= S_RD;
            end else begin
              s_r     <= s_r + CW'(1);
              state_r <= C_RD;
            end
          end
        end
        S_RD: state_r <= S_LAT;
        S_LAT: begin
          cs_r    <= cost_rd_r;
          k_r     <= '0;
          best_r  <= {1'b0, {50{1'b1}}};
          from_r  <= s_r[RW-1:0];
          state_r <= P_RD;
        end
        P_RD: state_r <= P_EV;
        P_EV: begin
          best_r <= best_n;
          from_r <= from_n;
          if (self_k) begin
            dwell_s_r <= pm_rd.dwell;
          end
          if (k_r == LAST) begin
            if (s_r == '0 || next_cost < lowest_r) begin
              lowest_r   <= next_cost;
              best_reg_r <= 4'(s_r[RW-1:0]);
            end
            if (s_r == LAST) begin
              s_r     <= '0;
              state_r <= N_RD;
            end else begin
              s_r     <= s_r + CW'(1);
              state_r <= S_RD;
            end
          end else begin
            k_r     <= k_r + CW'(1);
            state_r <= P_RD;
          end
        end
        N_RD: state_r <= N_WR;
        N_WR: begin
          if (s_r == LAST) begin
            bank_r  <= ~bank_r;
            state_r <= DEC;
          end else begin
            s_r     <= s_r + CW'(1);
            state_r <= N_RD;
          end
        end
        DEC: begin
          if (!blocked) begin
            count_r <= count_r + 32'd1;
            if (change && confirm_hit) begin
              if (emit) begin
                out_idx_r   <= start_n;
                last_r      <= start_n;
              end
              confirmed_r  <= best_reg_r;
              cand_valid_r <= 1'b0;
              cand_reg_r   <= '0;
              cand_cnt_r   <= '0;
              cand_start_r <= '0;
            end else if (change) begin
              cand_valid_r <= 1'b1;
              cand_reg_r   <= best_reg_r;
              cand_cnt_r   <= cnt_n;
              cand_start_r <= start_n;
            end else begin
              cand_valid_r <= 1'b0;
              cand_reg_r   <= '0;
              cand_cnt_r   <= '0;
              cand_start_r <= '0;
            end
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_change_index = out_idx_r;

endmodule
`default_nettype wire

// ----- rtl/vcpp_regime_mem.sv -----
// Regime table memory: centre, scale and log offset per regime.
// Depends on vcpp_pkg.
`default_nettype none
module vcpp_regime_mem #(
  parameter int REGIMES = 4,
  parameter int RW = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [RW-1:0]    wr_idx,
  input  vcpp_pkg::regime_t wr_data,
  input  logic [RW-1:0]    rd_idx,
  output vcpp_pkg::regime_t rd_data
);
  import vcpp_pkg::*;

  regime_t           mem [REGIMES];
  logic [REGIMES-1:0] vld_r;
  regime_t           rd_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx] <= wr_data;
    end
    rd_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wr_idx] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_idx];
    end
  end

  // unwritten entries read as their reset value
  always_comb begin
    if (rd_vld_r) begin
      rd_data = rd_r;
    end else begin
      rd_data.centre = '0;
      rd_data.scale  = SCALE_ONE;
      rd_data.offset = '0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/vcpp_path_mem.sv -----
// Two-bank path metric memory (cost, dwell) with per-entry valid bits.
// Depends on vcpp_pkg.
`default_nettype none
module vcpp_path_mem #(
  parameter int REGIMES = 4,
  parameter int RW = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear,
  input  logic                  we,
  input  logic                  wr_bank,
  input  logic [RW-1:0]         wr_idx,
  input  vcpp_pkg::path_entry_t wr_data,
  input  logic                  rd_bank,
  input  logic [RW-1:0]         rd_idx,
  output vcpp_pkg::path_entry_t rd_data
);
  import vcpp_pkg::*;

  path_entry_t        mem [2][REGIMES];
  logic [REGIMES-1:0] vld_r [2];
  path_entry_t        rd_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_bank][wr_idx] <= wr_data;
    end
    rd_r <= mem[rd_bank][rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      vld_r[0] <= '0;
      vld_r[1] <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wr_bank][wr_idx] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_bank][rd_idx];
    end
  end

  // fresh pass: cost zero, dwell one
  always_comb begin
    if (rd_vld_r) begin
      rd_data = rd_r;
    end else begin
      rd_data.cost  = '0;
      rd_data.dwell = DWELL_W'(1);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/vcpp_cost_unit.sv -----
// Four-stage Huber regime cost pipeline; the final stage adds the regime offset, with no multiplier.
// Depends on vcpp_pkg.
`default_nettype none
module vcpp_cost_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic signed [31:0] sample,
  input  vcpp_pkg::regime_t regime,
  input  logic [30:0]       knee,
  output logic              done,
  output vcpp_pkg::cost_t   cost
);
  import vcpp_pkg::*;

  logic signed [32:0] d;
  logic [32:0]        mag;
  logic [63:0]        p1_r;
  logic signed [31:0] off1_r, off2_r, off3_r;
  logic [3:0]         v_r;
  logic [47:0]        a;
  logic               le;
  logic [48:0]        t;
  logic [30:0]        op_a;
  logic [31:0]        op_b;
  logic [62:0]        m2_r, m3_r;
  logic [16:0]        thi2_r;
  logic               le2_r, le3_r;
  logic [47:0]        phi3_r;
  logic [80:0]        prod;
  logic [45:0]        h;
  cost_t              cost_r;

  always_comb begin
    d   = {regime.centre[31], regime.centre};
    d   = {sample[31], sample} - d;
    mag = d[32] ? 33'(-d) : 33'(d);
    a   = p1_r[63:16];
    le  = a <= {17'b0, knee};
    t   = {a, 1'b0} - {18'b0, knee};
    op_a = le ? a[30:0] : knee;
    op_b = le ? {1'b0, a[30:0]} : t[31:0];
    prod = {1'b0, phi3_r, 32'b0} + {18'b0, m3_r};
    if (le3_r) begin
      h = 46'(m3_r >> 17);
    end else if (prod[80:63] != '0) begin
      h = HUBER_MAX;
    end else begin
      h = prod[62:17];
    end
  end

  always_ff @(posedge clk) begin
    p1_r   <= mag[31:0] * regime.scale;
    off1_r <= regime.offset;
    m2_r   <= op_a * op_b;
    thi2_r <= t[48:32];
    le2_r  <= le;
    off2_r <= off1_r;
    phi3_r <= knee * thi2_r;
    m3_r   <= m2_r;
    le3_r  <= le2_r;
    off3_r <= off2_r;
    cost_r <= $signed({2'b0, h}) + COST_W'(off3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], start};
    end
  end

  assign done = v_r[3];
  assign cost = cost_r;

endmodule
`default_nettype wire

// ----- rtl/vcpp_checker.sv -----
// Port-level checker for viterbi_change_point_pass, bound to the top level.
// Depends on viterbi_change_point_pass ports only.
`default_nettype none
module vcpp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_change_index
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_change_index))
    else $error("stalled result changed");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_kind |=> in_stall)
    else $error("sample beat not followed by busy");

  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind |=> !in_stall)
    else $error("load beat held the input");

endmodule

bind viterbi_change_point_pass vcpp_checker u_vcpp_checker (
  .clk, .rst_n, .in_valid, .in_stall, .in_kind, .out_valid, .out_stall,
  .out_change_index
);
`default_nettype wire
